@@ hw/rtl/abkf_pkg.sv @@
// Shared types, codes and saturation helpers for the angle/bias Kalman filter.
package abkf_pkg;

  localparam logic [1:0] REG_QA = 2'd0;
  localparam logic [1:0] REG_QB = 2'd1;
  localparam logic [1:0] REG_R  = 2'd2;

  localparam logic [31:0] QA_RESET = 32'd4294967;
  localparam logic [31:0] QB_RESET = 32'd12884902;
  localparam logic [31:0] R_RESET  = 32'd128849019;

  localparam logic [47:0] S48_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [63:0] PROD_CAP = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH} state_t;

  typedef enum logic [3:0] {
    OP_ANGLE, OP_T, OP_P00, OP_P0110, OP_P11, OP_K0, OP_K1,
    OP_UB, OP_UA, OP_C10, OP_C11, OP_C00, OP_C01
  } op_t;

  typedef enum logic [1:0] {KIND_MUL, KIND_DIV, KIND_DIRECT} kind_t;

  localparam logic [3:0] LAST_STEP = 4'd12;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic div_start;
    logic wb;
    logic out_load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } sts_t;

  // bias update runs before the angle update so both see the same innovation
  function automatic op_t op_of(input logic [3:0] step);
    op_t o;
    case (step)
      4'd0:    o = OP_ANGLE;
      4'd1:    o = OP_T;
      4'd2:    o = OP_P00;
      4'd3:    o = OP_P0110;
      4'd4:    o = OP_P11;
      4'd5:    o = OP_K0;
      4'd6:    o = OP_K1;
      4'd7:    o = OP_UB;
      4'd8:    o = OP_UA;
      4'd9:    o = OP_C10;
      4'd10:   o = OP_C11;
      4'd11:   o = OP_C00;
      default: o = OP_C01;
    endcase
    return o;
  endfunction

  function automatic kind_t kind_of(input op_t o);
    kind_t k;
    case (o)
      OP_P0110:     k = KIND_DIRECT;
      OP_K0, OP_K1: k = KIND_DIV;
      default:      k = KIND_MUL;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [47:0] sat48(input logic signed [65:0] v);
    logic [47:0] r;
    if (v > 66'sh7FFF_FFFF_FFFF) r = 48'h7FFF_FFFF_FFFF;
    else if (v < -66'sh8000_0000_0000) r = 48'h8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/abkf_if.sv @@
// Sample, result and configuration channel interfaces.
interface abkf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] gyro_rate;
  logic        [15:0] time_step;
  modport source (output valid, measured_angle, gyro_rate, time_step, input ready);
  modport sink (input valid, measured_angle, gyro_rate, time_step, output ready);
endinterface

interface abkf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fused_angle;
  logic signed [31:0] fused_rate;
  modport source (output valid, fused_angle, fused_rate, input ready);
  modport sink (input valid, fused_angle, fused_rate, output ready);
endinterface

interface abkf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/abkf_mul.sv @@
// Shared multi-cycle fixed-point multiplier with rounding and capping.
module abkf_mul import abkf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic        [47:0] a_mag,
  input  logic        [47:0] b_mag,
  input  logic               neg,
  input  logic               sh32,
  output logic               done,
  output logic signed [63:0] res
);

  typedef enum logic [2:0] {MP_IDLE, MP_LO, MP_HI, MP_SUM, MP_OUT} mul_ph_t;

  localparam logic [95:0] RC32 = 96'h8000_0000;
  localparam logic [95:0] RC16 = 96'h8000;

  mul_ph_t     ph;
  logic [47:0] a_r, b_r;
  logic        neg_r, sh_r;
  logic [71:0] pp;
  logic [95:0] acc;
  logic [79:0] q80;
  logic [63:0] capped;

  always_comb begin
    q80    = sh_r ? {16'b0, acc[95:32]} : acc[95:16];
    capped = (q80 > 80'(PROD_CAP)) ? PROD_CAP : q80[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= MP_IDLE;
      done <= 1'b0;
    end else begin
      done <= (ph == MP_OUT);
      case (ph)
        MP_IDLE: begin
          if (start) begin
            a_r   <= a_mag;
            b_r   <= b_mag;
            neg_r <= neg;
            sh_r  <= sh32;
            ph    <= MP_LO;
          end
        end
        MP_LO: begin
          pp <= a_r * b_r[23:0];
          ph <= MP_HI;
        end
        MP_HI: begin
          acc <= {24'b0, pp} + (sh_r ? RC32 : RC16);
          pp  <= a_r * b_r[47:24];
          ph  <= MP_SUM;
        end
        MP_SUM: begin
          acc <= acc + {pp, 24'b0};
          ph  <= MP_OUT;
        end
        MP_OUT: begin
          res  <= neg_r ? -capped : capped;
          ph   <= MP_IDLE;
        end
        default: ph <= MP_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/abkf_div.sv @@
// Restoring divider for the Kalman gains, one quotient bit a cycle.
module abkf_div import abkf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic        [47:0] num_mag,
  input  logic        [48:0] den_mag,
  input  logic               neg,
  input  logic               den_zero,
  output logic               done,
  output logic signed [47:0] res
);

  // 48 numerator bits plus 32 fraction bits
  localparam int DIV_STEPS = 80;

  logic [47:0] nsh, q, q_next, mag_out;
  logic [48:0] d_r, r;
  logic [49:0] rs, diff;
  logic        ge, ovf, neg_r, zero_r, busy, fin;
  logic [6:0]  cnt;

  always_comb begin
    rs      = {r, nsh[47]};
    diff    = rs - {1'b0, d_r};
    ge      = rs >= {1'b0, d_r};
    q_next  = {q[46:0], ge};
    mag_out = (ovf | q[47]) ? S48_MAX : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= !start && busy && (cnt == 7'(DIV_STEPS - 1));
      if (start) begin
        nsh    <= num_mag;
        d_r    <= den_mag;
        r      <= '0;
        q      <= '0;
        ovf    <= 1'b0;
        cnt    <= '0;
        neg_r  <= neg;
        zero_r <= den_zero;
        busy   <= 1'b1;
      end else if (busy) begin
        r   <= ge ? diff[48:0] : rs[48:0];
        nsh <= {nsh[46:0], 1'b0};
        q   <= q_next;
        ovf <= ovf | q[47];   // a set top bit shifted out means saturation
        cnt <= cnt + 7'd1;
        if (cnt == 7'(DIV_STEPS - 1)) busy <= 1'b0;
      end
      if (fin) res <= zero_r ? 48'sd0 : (neg_r ? -mag_out : mag_out);
    end
  end

endmodule

@@ hw/rtl/abkf_datapath.sv @@
// Filter state, operand selection, write-back and the shared arithmetic units.
module abkf_datapath import abkf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_index,
  input  logic        [31:0] cfg_data,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] gyro_rate,
  input  logic        [15:0] time_step,
  output logic signed [31:0] fused_angle,
  output logic signed [31:0] fused_rate
);

  logic        [31:0] qa, qb, rn;
  logic signed [31:0] meas, gyro;
  logic        [15:0] dt;
  logic signed [31:0] angle, bias;
  logic signed [47:0] p00, p01, p10, p11, t, k0, k1;

  logic signed [32:0] gb, y;
  logic signed [65:0] inner_w, base, acc_w;
  logic signed [47:0] inner, num;
  logic signed [49:0] s_w, neg_s;
  logic signed [48:0] opa, opb, neg_a, neg_b;
  logic        [47:0] a_mag, b_mag, num_mag, neg_num;
  logic        [48:0] den_mag;
  logic               sh32, sub;
  logic signed [63:0] mq;
  logic signed [47:0] dq;

  always_comb begin
    gb      = 33'(gyro) - 33'(bias);
    y       = 33'(meas) - 33'(angle);
    inner_w = 66'(t) - 66'(p01) - 66'(p10) + 66'(qa);
    inner   = sat48(inner_w);
    s_w     = 50'(p00) + 50'(rn);

    opa  = '0;
    opb  = '0;
    sh32 = 1'b1;
    case (cmd.op)
      OP_ANGLE: begin opa = 49'(dt); opb = 49'(gb);    sh32 = 1'b0; end
      OP_T:     begin opa = 49'(dt); opb = 49'(p11);   sh32 = 1'b0; end
      OP_P00:   begin opa = 49'(dt); opb = 49'(inner); sh32 = 1'b0; end
      OP_P11:   begin opa = 49'(qb); opb = 49'(dt);    sh32 = 1'b0; end
      OP_UB:    begin opa = 49'(k1); opb = 49'(y);   end
      OP_UA:    begin opa = 49'(k0); opb = 49'(y);   end
      OP_C10:   begin opa = 49'(k1); opb = 49'(p00); end
      OP_C11:   begin opa = 49'(k1); opb = 49'(p01); end
      OP_C00:   begin opa = 49'(k0); opb = 49'(p00); end
      OP_C01:   begin opa = 49'(k0); opb = 49'(p01); end
      default:  begin opa = '0; opb = '0; end
    endcase
    neg_a = -opa;
    neg_b = -opb;
    a_mag = opa[48] ? neg_a[47:0] : opa[47:0];
    b_mag = opb[48] ? neg_b[47:0] : opb[47:0];

    num     = (cmd.op == OP_K1) ? p10 : p00;
    neg_num = -num;
    num_mag = num[47] ? neg_num : num;
    neg_s   = -s_w;
    den_mag = s_w[49] ? neg_s[48:0] : s_w[48:0];

    sub = 1'b0;
    case (cmd.op)
      OP_ANGLE, OP_UA: base = 66'(angle);
      OP_UB:           base = 66'(bias);
      OP_P00:          base = 66'(p00);
      OP_P11:          base = 66'(p11);
      OP_C00:          begin base = 66'(p00); sub = 1'b1; end
      OP_C01:          begin base = 66'(p01); sub = 1'b1; end
      OP_C10:          begin base = 66'(p10); sub = 1'b1; end
      OP_C11:          begin base = 66'(p11); sub = 1'b1; end
      default:         base = '0;
    endcase
    acc_w = sub ? base - 66'(mq) : base + 66'(mq);
  end

  abkf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a_mag (a_mag),
    .b_mag (b_mag),
    .neg   (opa[48] ^ opb[48]),
    .sh32  (sh32),
    .done  (sts.mul_done),
    .res   (mq)
  );

  abkf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num_mag  (num_mag),
    .den_mag  (den_mag),
    .neg      (num[47] ^ s_w[49]),
    .den_zero (s_w == 50'sd0),
    .done     (sts.div_done),
    .res      (dq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      qa    <= QA_RESET;
      qb    <= QB_RESET;
      rn    <= R_RESET;
      angle <= '0;
      bias  <= '0;
      p00   <= '0;
      p01   <= '0;
      p10   <= '0;
      p11   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_QA:  qa <= cfg_data;
          REG_QB:  qb <= cfg_data;
          REG_R:   rn <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        meas <= measured_angle;
        gyro <= gyro_rate;
        dt   <= time_step;
      end
      if (cmd.wb) begin
        case (cmd.op)
          OP_ANGLE, OP_UA: angle <= sat32(acc_w);
          OP_UB:           bias  <= sat32(acc_w);
          OP_T:            t     <= mq[47:0];
          OP_P00, OP_C00:  p00   <= sat48(acc_w);
          OP_P11, OP_C11:  p11   <= sat48(acc_w);
          OP_C10:          p10   <= sat48(acc_w);
          OP_C01:          p01   <= sat48(acc_w);
          OP_P0110: begin
            p01 <= sat48(66'(p01) - 66'(t));
            p10 <= sat48(66'(p10) - 66'(t));
          end
          OP_K0:           k0    <= dq;
          OP_K1:           k1    <= dq;
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        fused_angle <= angle;
        fused_rate  <= sat32(66'(gyro) - 66'(bias));
      end
    end
  end

endmodule

@@ hw/rtl/abkf_ctrl.sv @@
// Sequencer that steps the datapath through predict and update for each word.
module abkf_ctrl import abkf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t     state, state_next;
  logic [3:0] step;
  op_t        op;
  kind_t      kind;
  logic       done;
  logic       out_free;

  always_comb begin
    op       = op_of(step);
    kind     = kind_of(op);
    done     = (kind == KIND_DIV) ? sts.div_done : sts.mul_done;
    out_free = !out_valid || out_ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ISSUE;
      ST_ISSUE: begin
        if (kind != KIND_DIRECT) state_next = ST_WAIT;
        else if (step == LAST_STEP) state_next = ST_FINISH;
      end
      ST_WAIT: begin
        if (done) state_next = (step == LAST_STEP) ? ST_FINISH : ST_ISSUE;
      end
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.op   = op;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_ISSUE: begin
        cmd.mul_start = (kind == KIND_MUL);
        cmd.div_start = (kind == KIND_DIV);
        cmd.wb        = (kind == KIND_DIRECT);
      end
      ST_WAIT:   cmd.wb = done;
      ST_FINISH: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) step <= '0;
      else if (cmd.wb) step <= step + 4'd1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/angle_bias_kalman_filter_unit.sv @@
// Top level of the angle and gyro-bias Kalman filter.
// Each sample runs through ten multiplies, two 80-step gain divisions, one
// direct step and a finish step before the result word is valid.
// One sample is in flight at a time; the next sample is taken while a
// result word waits in the output register.
// Reset (rst, synchronous): estimates, covariance cleared, noise to defaults.
module angle_bias_kalman_filter_unit import abkf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  abkf_in_if.sink    sample,
  abkf_out_if.source result,
  abkf_cfg_if.sink   cfg
);

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  abkf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  abkf_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .measured_angle (sample.measured_angle),
    .gyro_rate      (sample.gyro_rate),
    .time_step      (sample.time_step),
    .fused_angle    (result.fused_angle),
    .fused_rate     (result.fused_rate)
  );

`ifndef SYNTHESIS
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result.valid || result.ready))
    else $error("result word overwritten while pending");

  a_one_unit_done: assert property (@(posedge clk) disable iff (rst)
    !(sts.mul_done && sts.div_done))
    else $error("multiplier and divider finished together");

  a_one_sample: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("second sample taken while one is in flight");

  a_start_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !cmd.div_start && !cmd.wb)
    else $error("conflicting datapath commands");
`endif

endmodule

@@ tb/sv/abkf_fusion_board.sv @@
// Scoreboard class: fixed-point predictor of the angle/bias Kalman filter and result checking.
class abkf_fusion_board;
  logic [31:0] qa, qb, rn;
  longint angle, bias;
  longint pc[4];
  logic signed [31:0] exp_angle[$];
  logic signed [31:0] exp_rate[$];
  int errors;

  localparam longint S32MAX = 64'sd2147483647;
  localparam longint S32MIN = -64'sd2147483648;
  localparam longint S48MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint S48MIN = -64'sh8000_0000_0000;

  function new();
    errors = 0;
    reset_state();
  endfunction

  function void reset_state();
    qa = abkf_pkg::QA_RESET;
    qb = abkf_pkg::QB_RESET;
    rn = abkf_pkg::R_RESET;
    angle = 0;
    bias = 0;
    foreach (pc[i]) pc[i] = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      abkf_pkg::REG_QA: qa = val;
      abkf_pkg::REG_QB: qb = val;
      abkf_pkg::REG_R:  rn = val;
      default: ;
    endcase
  endfunction

  function longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // exact product, rounded half away from zero, magnitude capped at 2^62
  function longint mul_round(longint a, longint b, int sh);
    logic [127:0] p;
    logic [127:0] q;
    logic [63:0] ma, mb;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = ma * mb;
    p = p + (128'd1 << (sh - 1));
    q = p >> sh;
    if (q > 128'h4000_0000_0000_0000) q = 128'h4000_0000_0000_0000;
    return ((a < 0) != (b < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function longint gain(longint num, longint den);
    logic [127:0] n, d, q;
    if (den == 0) return 0;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (n << 32) / d;
    if (q > S48MAX) q = S48MAX;
    return ((num < 0) != (den < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function void note_sample(logic signed [31:0] meas, logic signed [31:0] gyro,
                            logic [15:0] dt_in);
    longint m, g, dt, p00, p01, p10, p11, t, inner, s, k0, k1, y;
    m = meas;
    g = gyro;
    dt = dt_in;
    p00 = pc[0]; p01 = pc[1]; p10 = pc[2]; p11 = pc[3];
    angle = clip(angle + mul_round(dt, g - bias, 16), S32MIN, S32MAX);
    t = mul_round(dt, p11, 16);
    inner = clip(t - p01 - p10 + longint'(qa), S48MIN, S48MAX);
    p00 = clip(p00 + mul_round(dt, inner, 16), S48MIN, S48MAX);
    p01 = clip(p01 - t, S48MIN, S48MAX);
    p10 = clip(p10 - t, S48MIN, S48MAX);
    p11 = clip(p11 + mul_round(longint'(qb), dt, 16), S48MIN, S48MAX);
    s = p00 + longint'(rn);
    k0 = gain(p00, s);
    k1 = gain(p10, s);
    y = m - angle;
    angle = clip(angle + mul_round(k0, y, 32), S32MIN, S32MAX);
    bias = clip(bias + mul_round(k1, y, 32), S32MIN, S32MAX);
    pc[0] = clip(p00 - mul_round(k0, p00, 32), S48MIN, S48MAX);
    pc[1] = clip(p01 - mul_round(k0, p01, 32), S48MIN, S48MAX);
    pc[2] = clip(p10 - mul_round(k1, p00, 32), S48MIN, S48MAX);
    pc[3] = clip(p11 - mul_round(k1, p01, 32), S48MIN, S48MAX);
    exp_angle.push_back(angle[31:0]);
    exp_rate.push_back(32'(clip(g - bias, S32MIN, S32MAX)));
  endfunction

  function void check_result(logic signed [31:0] fa, logic signed [31:0] fr);
    logic signed [31:0] ea, er;
    if (exp_angle.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word angle=%0d rate=%0d", fa, fr);
      return;
    end
    ea = exp_angle.pop_front();
    er = exp_rate.pop_front();
    if (fa !== ea || fr !== er) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: angle exp %0d got %0d, rate exp %0d got %0d", ea, fa, er, fr);
    end
  endfunction

  function int pending();
    return exp_angle.size();
  endfunction
endclass

@@ tb/sv/angle_bias_kalman_filter_unit_test.sv @@
// Testbench top: drives samples and register writes, checks fused angle and rate words.
module angle_bias_kalman_filter_unit_test;
  import abkf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  abkf_in_if  sample();
  abkf_out_if result();
  abkf_cfg_if cfg();

  angle_bias_kalman_filter_unit dut (.clk(clk), .rst(rst), .sample(sample),
                                     .result(result), .cfg(cfg));

  abkf_fusion_board board;
  longint cycles;
  bit quiet;  // no idling in the last part
  bit done_sending;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 64'd2_000_000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: accept and check, with random stall bursts
  initial begin
    int n;
    result.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        result.ready = 0;
        n = $urandom_range(1, 15);
        repeat (n) @(negedge clk);
      end
      result.ready = 1;
      @(posedge clk);
      if (result.valid && result.ready)
        board.check_result(result.fused_angle, result.fused_rate);
      @(negedge clk);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg.valid = 1;
    cfg.index = idx;
    cfg.data = val;
    do @(posedge clk); while (!cfg.ready);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg.valid = 0;
  endtask

  task automatic send_sample(logic [31:0] m, logic [31:0] g, logic [15:0] dt);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 15);
      repeat (n) @(negedge clk);
    end
    sample.valid = 1;
    sample.measured_angle = m;
    sample.gyro_rate = g;
    sample.time_step = dt;
    do @(posedge clk); while (!sample.ready);
    board.note_sample(m, g, dt);
    @(negedge clk);
    sample.valid = 0;
  endtask

  task automatic drain();
    while (board.pending() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return $signed($urandom_range(0, 2 * 5898240)) - 5898240;  // +-90 deg
    endcase
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 2 * 32768000)) - 32768000;
    endcase
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 5))
      0: return 16'($urandom());
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(1, 1000));  // typical ms range
    endcase
  endfunction

  initial begin
    logic [31:0] qa_set[4], qb_set[4], r_set[4];
    board = new();
    quiet = 0;
    rst = 1;
    sample.valid = 0;
    sample.measured_angle = 0;
    sample.gyro_rate = 0;
    sample.time_step = 0;
    cfg.valid = 0;
    cfg.index = REG_QA;
    cfg.data = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes at reset settings
    send_sample(0, 0, 0);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    send_sample(32'h8000_0000, 32'h8000_0000, 16'hFFFF);
    send_sample(32'h0001_0000, 32'h0000_8000, 16'd66);
    send_sample(32'hFFFF_FFFF, 32'h8000_0000, 16'h0001);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
    drain();
    // zero noise: all noise registers set to zero
    write_reg(REG_QA, 0);
    write_reg(REG_QB, 0);
    write_reg(REG_R, 0);
    write_reg(2'd3, 32'hDEAD_BEEF);  // unknown index, ignored
    send_sample(32'h0010_0000, 32'h0001_0000, 16'd100);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    drain();
    // saturating covariance growth
    write_reg(REG_QA, 32'hFFFF_FFFF);
    write_reg(REG_QB, 32'hFFFF_FFFF);
    write_reg(REG_R, 32'hFFFF_FFFF);
    repeat (8) send_sample(rand_angle(), rand_rate(), 16'hFFFF);
    drain();

    qa_set = '{32'd4294967, 32'd0, 32'hFFFF_FFFF, 32'd429496};
    qb_set = '{32'd12884902, 32'd0, 32'hFFFF_FFFF, 32'd1288490};
    r_set  = '{32'd128849019, 32'd0, 32'hFFFF_FFFF, 32'd1};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet = 1;
      if (ph < 4) begin
        write_reg(REG_QA, qa_set[ph]);
        write_reg(REG_QB, qb_set[ph]);
        write_reg(REG_R, r_set[ph]);
      end else begin
        write_reg(REG_QA, $urandom());
        write_reg(REG_QB, $urandom());
        write_reg(REG_R, $urandom());
      end
      repeat (215) send_sample(rand_angle(), rand_rate(), rand_dt());
      drain();
    end

    if (board.errors == 0 && board.pending() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
